// ===== rtl/rgb_to_cielab_pixel_macros.svh =====
// ----------------------------------------------------------------------------
// rgb to cielab assertion macros
// Shared concurrent assertion forms, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_CIELAB_PIXEL_MACROS_SVH
`define RGB_TO_CIELAB_PIXEL_MACROS_SVH

// same-cycle implication
`define RLAB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLAB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rlab_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb to cielab package
// Field widths, matrix coefficients, format codes and output constants.
// ----------------------------------------------------------------------------
package rlab_pkg;

    // field widths
    localparam int IN_W      = 8;
    localparam int OUT_W     = 18;
    localparam int BYTE_W    = 8;

    // fixed point layout
    localparam int COEF_FRAC = 20;
    localparam int COEF_W    = 20;
    localparam int ROM_FRAC  = 15;
    localparam int F_W       = ROM_FRAC + 1;
    localparam int PROD_W    = COEF_W + IN_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RAW_W     = 32;
    localparam int N_W       = 13;

    localparam longint unsigned ROUND_HALF = 64'd1 << (COEF_FRAC - 1);

    // parameter defaults
    localparam int INDEX_SCALE_DEF   = 16;
    localparam int ROM_DEPTH_DEF     = 4096;
    localparam int FRACTION_BITS_DEF = 8;

    // output format codes
    typedef enum logic {
        FMT_FIXED = 1'b0,
        FMT_BYTE  = 1'b1
    } fmt_t;

    // white-normalized linear rgb to xyz matrix, q.20, rounded
    localparam logic [COEF_W-1:0] COEF [3][3] = '{
        '{ COEF_W'(((64'd412453 << (COEF_FRAC + 1)) + 64'd950460) / 64'd1900920),
           COEF_W'(((64'd357580 << (COEF_FRAC + 1)) + 64'd950460) / 64'd1900920),
           COEF_W'(((64'd180423 << (COEF_FRAC + 1)) + 64'd950460) / 64'd1900920) },
        '{ COEF_W'(((64'd212671 << (COEF_FRAC + 1)) + 64'd1000000) / 64'd2000000),
           COEF_W'(((64'd715160 << (COEF_FRAC + 1)) + 64'd1000000) / 64'd2000000),
           COEF_W'(((64'd72169  << (COEF_FRAC + 1)) + 64'd1000000) / 64'd2000000) },
        '{ COEF_W'(((64'd19334  << (COEF_FRAC + 1)) + 64'd1088750) / 64'd2177500),
           COEF_W'(((64'd119193 << (COEF_FRAC + 1)) + 64'd1088750) / 64'd2177500),
           COEF_W'(((64'd950227 << (COEF_FRAC + 1)) + 64'd1088750) / 64'd2177500) }
    };

    // fixed point format: L = 116 fy - 16, a = 500 dxy, b = 200 dyz
    localparam logic signed [RAW_W-1:0] L0_MULT   = RAW_W'(116);
    localparam logic signed [RAW_W-1:0] L0_OFFSET = RAW_W'(16 << ROM_FRAC);
    localparam logic signed [RAW_W-1:0] A0_MULT   = RAW_W'(500);
    localparam logic signed [RAW_W-1:0] B0_MULT   = RAW_W'(200);

    // byte format: L = (2958 fy - 403 one) / 10 one, ab = (14732 d + 12850 one) / 100 one
    localparam logic signed [RAW_W-1:0] L1_MULT    = RAW_W'(2958);
    localparam logic signed [RAW_W-1:0] L1_OFFSET  = RAW_W'(403 << ROM_FRAC);
    localparam logic signed [RAW_W-1:0] AB1_MULT   = RAW_W'(14732);
    localparam logic signed [RAW_W-1:0] AB1_OFFSET = RAW_W'(12850);
    localparam logic signed [RAW_W-1:0] L1_LIMIT   = RAW_W'(2560);
    localparam logic signed [RAW_W-1:0] AB1_LIMIT  = RAW_W'(25600);

    // reciprocal constants for exact floor division of small values
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int          DIV10_SH  = 19;
    localparam logic [15:0] DIV25_MUL = 16'd5243;
    localparam int          DIV25_SH  = 17;

    // byte format value before the final divide
    typedef struct packed {
        logic           lo;
        logic           hi;
        logic [N_W-1:0] n;
    } byte_pre_t;

endpackage

// ===== rtl/rlab_rom.sv =====
// ----------------------------------------------------------------------------
// rlab_rom
// Constant f(t) table in q.15 with a registered read port.
// ----------------------------------------------------------------------------
module rlab_rom
    import rlab_pkg::*;
#(
    parameter int ROM_DEPTH = ROM_DEPTH_DEF,
    parameter int SPAN      = 255 * INDEX_SCALE_DEF
)(
    input  logic                         clk,
    input  logic                         en,
    input  logic [$clog2(ROM_DEPTH)-1:0] addr,
    output logic [F_W-1:0]               data
);

    typedef logic [F_W-1:0] rom_table_t [ROM_DEPTH];

    // one entry: linear segment near zero, cube root elsewhere, both by search
    function automatic logic [F_W-1:0] rom_value(input longint unsigned i);
        longint unsigned span;
        longint unsigned num;
        longint unsigned den;
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned k;
        span = longint'(SPAN);
        lo   = 0;
        if (i * 64'd24389 <= 64'd216 * span)
        begin
            num    = 64'd841 * 64'd29 * i + 64'd432 * span;
            den    = 64'd3132 * span;
            target = (num << (ROM_FRAC + 1)) + den;
            hi     = (64'd1 << F_W) - 64'd1;
            for (int s = 0; s <= F_W; s++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 64'd1) >> 1;
                    if (mid * 64'd2 * den <= target)
                        lo = mid;
                    else
                        hi = mid - 64'd1;
                end
            end
        end
        else
        begin
            target = i << (3 * (ROM_FRAC + 1));
            hi     = 64'd1 << ROM_FRAC;
            for (int s = 0; s <= F_W; s++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 64'd1) >> 1;
                    k   = 64'd2 * mid - 64'd1;
                    if (k * k * k * span <= target)
                        lo = mid;
                    else
                        hi = mid - 64'd1;
                end
            end
        end
        return F_W'(lo);
    endfunction

    function automatic rom_table_t build_table();
        rom_table_t t;
        for (int i = 0; i < ROM_DEPTH; i++)
            t[i] = rom_value(longint'(i));
        return t;
    endfunction

    localparam rom_table_t ROM_TABLE = build_table();

    logic [F_W-1:0] data_reg;

    // registered read
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= ROM_TABLE[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/rgb_to_cielab_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_cielab_pixel
// One 8-bit rgb pixel in, one cie L*a*b* triple (d65 white) out.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled and
// returns its result through seven register stages: matrix products, sums,
// table index, table read, format products, rounding, and a final divide and
// select. Each of the three table lookups has its own copy of the f(t) table,
// so no port is shared and the pipeline never waits on a lookup. A stall on the
// output backs up stage by stage, and an empty stage still takes a new
// transaction, so input stall rises only when every stage is full. There is
// no clearing pass after reset. output_format may be written only while no
// transaction is in flight; cfg_ready is always high.
`include "rgb_to_cielab_pixel_macros.svh"

module rgb_to_cielab_pixel
    import rlab_pkg::*;
#(
    parameter int INDEX_SCALE   = INDEX_SCALE_DEF,
    parameter int ROM_DEPTH     = ROM_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    output_format,
    // pixel input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IN_W-1:0]         red,
    input  logic [IN_W-1:0]         green,
    input  logic [IN_W-1:0]         blue,
    // result output
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] lightness,
    output logic signed [OUT_W-1:0] green_red,
    output logic signed [OUT_W-1:0] blue_yellow
);

    localparam int NSTG     = 7;
    localparam int IDX_W    = $clog2(ROM_DEPTH);
    localparam int SPAN     = 255 * INDEX_SCALE;
    localparam int LIM      = (SPAN < ROM_DEPTH - 1) ? SPAN : ROM_DEPTH - 1;
    localparam int SCALE_W  = $clog2(INDEX_SCALE + 1);
    localparam int IDXF_RAW = ACC_W + SCALE_W + 1 - COEF_FRAC;
    localparam int IDXF_W   = (IDXF_RAW > IDX_W) ? IDXF_RAW : IDX_W;
    localparam int SCL_W    = IDXF_W + COEF_FRAC;
    localparam int SH       = ROM_FRAC - FRACTION_BITS;

    localparam logic [IDXF_W-1:0]       LIM_F    = IDXF_W'(LIM);
    localparam logic [IDX_W-1:0]        LIM_I    = IDX_W'(LIM);
    localparam logic signed [RAW_W-1:0] HALF     = RAW_W'(1 << (SH - 1));
    localparam logic signed [RAW_W-1:0] OUT_MAX  = RAW_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RAW_W-1:0] OUT_MIN  = -RAW_W'(1 << (OUT_W - 1));
    localparam logic [BYTE_W-1:0]       BYTE_MAX = '1;

    // pipeline control
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   adv;

    // configuration
    fmt_t fmt_reg;

    // stage payloads
    logic [PROD_W-1:0]       prod_reg [3][3];
    logic [ACC_W-1:0]        acc_reg  [3];
    logic [IDX_W-1:0]        idx_reg  [3];
    logic [IDX_W-1:0]        idx_next [3];
    logic [F_W-1:0]          f_w      [3];
    logic signed [RAW_W-1:0] raw0_reg [3];
    logic signed [RAW_W-1:0] raw0_next[3];
    logic signed [RAW_W-1:0] raw1_reg [3];
    logic signed [RAW_W-1:0] raw1_next[3];
    logic signed [OUT_W-1:0] fix_reg  [3];
    logic signed [OUT_W-1:0] fix_next [3];
    byte_pre_t               pre_reg  [3];
    byte_pre_t               pre_next [3];
    logic signed [OUT_W-1:0] res_reg  [3];
    logic signed [OUT_W-1:0] res_next [3];

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTG] = !out_stall;
        for (int s = NSTG - 1; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s + 1];
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[NSTG-1];
    assign cfg_ready = 1'b1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                if (adv[s])
                    v_reg[s] <= v_reg[s - 1];
            end
        end
    end

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_FIXED;
        else if (cfg_valid)
            fmt_reg <= fmt_t'(output_format);
    end

    // stage 0: matrix products
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k][0] <= PROD_W'(COEF[k][0]) * PROD_W'(red);
                prod_reg[k][1] <= PROD_W'(COEF[k][1]) * PROD_W'(green);
                prod_reg[k][2] <= PROD_W'(COEF[k][2]) * PROD_W'(blue);
            end
        end
    end

    // stage 1: weighted sums
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= ACC_W'(prod_reg[k][0]) + ACC_W'(prod_reg[k][1])
                              + ACC_W'(prod_reg[k][2]);
        end
    end

    // stage 2: scale, round half up, clamp to the table range
    always_comb
    begin
        logic [SCL_W-1:0]  scaled;
        logic [IDXF_W-1:0] idx_full;
        for (int k = 0; k < 3; k++)
        begin
            scaled   = SCL_W'(acc_reg[k]) * SCL_W'(INDEX_SCALE) + SCL_W'(ROUND_HALF);
            idx_full = scaled[SCL_W-1:COEF_FRAC];
            if (idx_full > LIM_F)
                idx_next[k] = LIM_I;
            else
                idx_next[k] = idx_full[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
            idx_reg <= idx_next;
    end

    // stage 3: table lookups
    for (genvar g = 0; g < 3; g++)
    begin : g_rom
        rlab_rom #(
            .ROM_DEPTH (ROM_DEPTH),
            .SPAN      (SPAN)
        ) u_rom (
            .clk  (clk),
            .en   (adv[3]),
            .addr (idx_reg[g]),
            .data (f_w[g])
        );
    end

    // stage 4: differences and format products
    always_comb
    begin
        logic signed [RAW_W-1:0] fx;
        logic signed [RAW_W-1:0] fy;
        logic signed [RAW_W-1:0] fz;
        logic signed [RAW_W-1:0] dxy;
        logic signed [RAW_W-1:0] dyz;
        fx  = signed'(RAW_W'(f_w[0]));
        fy  = signed'(RAW_W'(f_w[1]));
        fz  = signed'(RAW_W'(f_w[2]));
        dxy = fx - fy;
        dyz = fy - fz;
        raw0_next[0] = fy * L0_MULT - L0_OFFSET;
        raw0_next[1] = dxy * A0_MULT;
        raw0_next[2] = dyz * B0_MULT;
        raw1_next[0] = fy * L1_MULT - L1_OFFSET;
        raw1_next[1] = dxy * AB1_MULT;
        raw1_next[2] = dyz * AB1_MULT;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            raw0_reg <= raw0_next;
            raw1_reg <= raw1_next;
        end
    end

    // stage 5: fixed point rounding and saturation, byte pre-divide
    always_comb
    begin
        logic signed [RAW_W-1:0] r;
        logic signed [RAW_W-1:0] q;
        for (int k = 0; k < 3; k++)
        begin
            r = (raw0_reg[k] + HALF) >>> SH;
            if (r > OUT_MAX)
                fix_next[k] = OUT_MAX[OUT_W-1:0];
            else if (r < OUT_MIN)
                fix_next[k] = OUT_MIN[OUT_W-1:0];
            else
                fix_next[k] = r[OUT_W-1:0];
        end
        // lightness: floor of q / 10
        q = raw1_reg[0] >>> ROM_FRAC;
        pre_next[0].lo = (q < 0);
        pre_next[0].hi = (q >= L1_LIMIT);
        pre_next[0].n  = q[N_W-1:0];
        // chroma: floor of q / 100 as floor of (q / 4) / 25
        for (int k = 1; k < 3; k++)
        begin
            q = (raw1_reg[k] >>> ROM_FRAC) + AB1_OFFSET;
            pre_next[k].lo = (q < 0);
            pre_next[k].hi = (q >= AB1_LIMIT);
            pre_next[k].n  = q[N_W+1:2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            fix_reg <= fix_next;
            pre_reg <= pre_next;
        end
    end

    // stage 6: reciprocal divide, byte saturation, format select
    always_comb
    begin
        logic [N_W+15:0]   prod;
        logic [BYTE_W-1:0] quo;
        logic [BYTE_W-1:0] byte_val;
        for (int k = 0; k < 3; k++)
        begin
            if (k == 0)
            begin
                prod = (N_W + 16)'(pre_reg[k].n) * (N_W + 16)'(DIV10_MUL);
                quo  = prod[DIV10_SH+BYTE_W-1:DIV10_SH];
            end
            else
            begin
                prod = (N_W + 16)'(pre_reg[k].n) * (N_W + 16)'(DIV25_MUL);
                quo  = prod[DIV25_SH+BYTE_W-1:DIV25_SH];
            end
            if (pre_reg[k].lo)
                byte_val = '0;
            else if (pre_reg[k].hi)
                byte_val = BYTE_MAX;
            else
                byte_val = quo;
            case (fmt_reg)
                FMT_BYTE: res_next[k] = signed'(OUT_W'(byte_val));
                default:  res_next[k] = fix_reg[k];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
            res_reg <= res_next;
    end

    assign lightness   = res_reg[0];
    assign green_red   = res_reg[1];
    assign blue_yellow = res_reg[2];

    // checks
    `RLAB_ASSERT_IMP(a_stall_full, in_stall, (&v_reg) && out_stall,
        "input stalled while a stage is empty")
    `RLAB_ASSERT_NXT(a_enter, in_valid && !in_stall, v_reg[0],
        "accepted transaction did not enter the pipeline")
    `RLAB_ASSERT_NXT(a_hold, v_reg[5] && !adv[5], v_reg[5],
        "blocked stage lost its transaction")
    `RLAB_ASSERT_IMP(a_idx_range, v_reg[2],
        (idx_reg[0] <= LIM_I) && (idx_reg[1] <= LIM_I) && (idx_reg[2] <= LIM_I),
        "table index beyond its limit")

endmodule

// ===== test/tb_rgb_to_cielab_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_cielab_pixel
// Streams rgb pixels through the cie L*a*b* converter in both output formats,
// predicts every L*, a* and b* with an independent fixed point model and
// checks each result in order, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_rgb_to_cielab_pixel;
    import rlab_pkg::*;

    // timing and run control
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int PIPE_LATENCY  = 7;
    localparam int HANG_LIMIT    = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int NORMAL_IDLE   = 12;

    // conversion constants
    localparam int  SCALE     = 16;
    localparam int  SPAN      = 255 * SCALE;
    localparam int  IDX_LIMIT = (SPAN < 4095) ? SPAN : 4095;
    localparam int  Q_SHIFT   = ROM_FRAC - FRACTION_BITS_DEF;
    localparam longint ONE_Q15 = longint'(1) << ROM_FRAC;
    localparam longint FIELD_MAX = 131071;
    localparam longint FIELD_MIN = -131072;

    // xyz weights in parts per million and the white point per row
    localparam longint unsigned WEIGHT_PPM [3][3] = '{
        '{ 412453, 357580, 180423 },
        '{ 212671, 715160,  72169 },
        '{  19334, 119193, 950227 }
    };
    localparam longint unsigned WHITE_PPM [3] = '{ 950460, 1000000, 1088750 };

    // directed pixels: corners, primaries, darks in the linear segment, grays
    localparam logic [23:0] CORNER_PIXELS [12] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'h010101, 24'h010000, 24'h000001, 24'h808080
    };

    typedef struct {
        logic [IN_W-1:0]         r;
        logic [IN_W-1:0]         g;
        logic [IN_W-1:0]         b;
        logic signed [OUT_W-1:0] lightness;
        logic signed [OUT_W-1:0] green_red;
        logic signed [OUT_W-1:0] blue_yellow;
    } lab_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    output_format = FMT_FIXED;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [IN_W-1:0]         red = '0;
    logic [IN_W-1:0]         green = '0;
    logic [IN_W-1:0]         blue = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] lightness;
    logic signed [OUT_W-1:0] green_red;
    logic signed [OUT_W-1:0] blue_yellow;

    // testbench state
    logic [23:0]          pixel_queue [$];
    lab_result_t          lab_expected [$];
    longint unsigned      xyz_coef [3][3];
    int                   cbrt_rom [0:SPAN];
    fmt_t                 format_shadow = FMT_FIXED;
    logic                 in_taken = 1'b0;
    int                   idle_pct = NORMAL_IDLE;
    int                   stall_pct = NORMAL_IDLE;
    int                   pixels_issued = 0;
    int                   results_checked = 0;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;

    rgb_to_cielab_pixel DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .output_format(output_format),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lightness    (lightness),
        .green_red    (green_red),
        .blue_yellow  (blue_yellow)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // floor division for a positive divisor
    function automatic longint div_floor(longint v, longint d);
        if (v >= 0)
            return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // q.15 f(t) for t = i / SPAN: linear segment near zero, else cube root
    function automatic int f_of_index(int unsigned i);
        longint unsigned ii;
        longint unsigned num;
        longint unsigned den;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned k;
        longint unsigned target;
        ii = 64'(i);
        if (ii * 24389 <= 216 * SPAN)
        begin
            num = 841 * 29 * ii + 4 * 108 * SPAN;
            den = 3132 * SPAN;
            return int'(((num << (ROM_FRAC + 1)) + den) / (2 * den));
        end
        // largest v with (2v-1)^3 * SPAN <= i * 2^48
        lo = 0;
        hi = longint'(1) << ROM_FRAC;
        target = ii << (3 * (ROM_FRAC + 1));
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            if (k * k * k * SPAN <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return int'(lo);
    endfunction

    // q.15 value rounded half up to the output fraction, saturated
    function automatic longint to_fixed_out(longint q15);
        return clip(div_floor(q15 + (longint'(1) << (Q_SHIFT - 1)), longint'(1) << Q_SHIFT),
                    FIELD_MIN, FIELD_MAX);
    endfunction

    // expected L*a*b* for one pixel under the given format
    function automatic lab_result_t cielab_of(logic [23:0] px, fmt_t fmt);
        longint unsigned chan [3];
        longint unsigned acc;
        longint unsigned idx;
        longint          f [3];
        longint          l_val;
        longint          a_val;
        longint          b_val;
        lab_result_t     res;
        chan[0] = 64'(px[23:16]);
        chan[1] = 64'(px[15:8]);
        chan[2] = 64'(px[7:0]);
        for (int k = 0; k < 3; k++)
        begin
            acc = xyz_coef[k][0] * chan[0] + xyz_coef[k][1] * chan[1]
                + xyz_coef[k][2] * chan[2];
            idx = (acc * SCALE + (longint'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
            if (idx > IDX_LIMIT)
                idx = 64'(IDX_LIMIT);
            f[k] = longint'(cbrt_rom[idx]);
        end
        if (fmt == FMT_FIXED)
        begin
            l_val = to_fixed_out(116 * f[1] - 16 * ONE_Q15);
            a_val = to_fixed_out(500 * (f[0] - f[1]));
            b_val = to_fixed_out(200 * (f[1] - f[2]));
        end
        else
        begin
            l_val = clip(div_floor(2958 * f[1] - 408 * ONE_Q15 + 5 * ONE_Q15, 10 * ONE_Q15),
                         0, 255);
            a_val = clip(div_floor(14732 * (f[0] - f[1]) + 12850 * ONE_Q15, 100 * ONE_Q15),
                         0, 255);
            b_val = clip(div_floor(14732 * (f[1] - f[2]) + 12850 * ONE_Q15, 100 * ONE_Q15),
                         0, 255);
        end
        res.r           = px[23:16];
        res.g           = px[15:8];
        res.b           = px[7:0];
        res.lightness   = OUT_W'(l_val);
        res.green_red   = OUT_W'(a_val);
        res.blue_yellow = OUT_W'(b_val);
        return res;
    endfunction

    // pixel driver, new transaction only once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                {red, green, blue} <= pixel_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // input side: predict each accepted pixel
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall && rst_n;
        if (rst_n && in_valid && !in_stall)
            lab_expected.push_back(cielab_of({red, green, blue}, format_shadow));
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        lab_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lab_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result L=%0d a=%0d b=%0d",
                             lightness, green_red, blue_yellow);
            end
            else
            begin
                want = lab_expected.pop_front();
                results_checked++;
                if (lightness !== want.lightness || green_red !== want.green_red ||
                    blue_yellow !== want.blue_yellow)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("rgb %0d,%0d,%0d: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                                 want.r, want.g, want.b, want.lightness, want.green_red,
                                 want.blue_yellow, lightness, green_red, blue_yellow);
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // wait until every pixel is back, then write output_format
    task automatic set_format(fmt_t fmt);
        while (results_checked != pixels_issued)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
        cfg_valid     <= 1'b1;
        output_format <= fmt;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        format_shadow = fmt;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random pixels: mostly uniform, plus darks, grays and saturated mixes
    task automatic queue_random_pixels(int count);
        int          kind;
        logic [7:0]  v;
        logic [23:0] px;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
                px = 24'($urandom);
            else if (kind < 75)
                px = {8'($urandom_range(6)), 8'($urandom_range(6)), 8'($urandom_range(6))};
            else if (kind < 90)
            begin
                v  = 8'($urandom);
                px = {v, v, v};
            end
            else
            begin
                px = 24'($urandom);
                for (int c = 0; c < 3; c++)
                    if ($urandom_range(1) == 1)
                        px[c*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            pixel_queue.push_back(px);
            pixels_issued++;
        end
    endtask

    // stimulus
    initial
    begin
        // matrix coefficients in q.20 and the f(t) table
        for (int row = 0; row < 3; row++)
            for (int col = 0; col < 3; col++)
                xyz_coef[row][col] = ((WEIGHT_PPM[row][col] << (COEF_FRAC + 1))
                                      + WHITE_PPM[row]) / (2 * WHITE_PPM[row]);
        for (int i = 0; i <= SPAN; i++)
            cbrt_rom[i] = f_of_index(i);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pixels in the reset format, then in byte coding
        foreach (CORNER_PIXELS[i])
        begin
            pixel_queue.push_back(CORNER_PIXELS[i]);
            pixels_issued++;
        end
        set_format(FMT_BYTE);
        foreach (CORNER_PIXELS[i])
        begin
            pixel_queue.push_back(CORNER_PIXELS[i]);
            pixels_issued++;
        end

        // random phases, one of them with no idling on either side
        set_format(FMT_FIXED);
        queue_random_pixels(320);
        set_format(FMT_BYTE);
        queue_random_pixels(320);
        set_format(FMT_FIXED);
        idle_pct  = 0;
        stall_pct = 0;
        queue_random_pixels(330);
        set_format(FMT_BYTE);
        idle_pct  = NORMAL_IDLE;
        stall_pct = NORMAL_IDLE;
        queue_random_pixels(330);

        // drain and let the pipeline settle
        while (results_checked != pixels_issued)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
        if (mismatches == 0 && lab_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
